// File: hw/rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg: shared types and constants of the priority task scheduler
// Action and status codes, sequencer states and the control structs that
// pass between the scheduler core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pts_pkg;

  // Default sizes
  localparam int unsigned NumPrioritiesDef = 8;
  localparam int unsigned NumTasksDef      = 16;

  // Fixed field widths
  localparam int unsigned ActionW = 2;
  localparam int unsigned PrioReqW = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned TickW   = 32;

  // Action codes
  localparam logic [ActionW-1:0] ACT_CREATE = 2'd0;
  localparam logic [ActionW-1:0] ACT_START  = 2'd1;
  localparam logic [ActionW-1:0] ACT_TICK   = 2'd2;

  // Status codes
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_PRIO  = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CREATE,
    S_TICK,
    S_ROT_HEAD,
    S_ROT_WALK,
    S_ROT_SPLICE,
    S_ROT_LINK,
    S_ROT_SELF,
    S_PICK,
    S_FIN
  } state_e;

  // Command from the top level to the core
  typedef struct packed {
    logic                go;
    logic [ActionW-1:0]  action;
    logic [PrioReqW-1:0] prio;
  } cmd_t;

  // Completion flags from the core to the top level
  typedef struct packed {
    logic               done;
    logic [StatusW-1:0] status;
    logic               sw;
  } res_flags_t;

endpackage : pts_pkg

`default_nettype wire

// File: hw/rtl/pts_link_mem.sv
// ----------------------------------------------------------------------------
// pts_link_mem: next-link store of the task queues
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_link_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : pts_link_mem

`default_nettype wire

// File: hw/rtl/pts_core.sv
// ----------------------------------------------------------------------------
// pts_core: scheduler sequencer
// Holds the ready bitmap, queue head/tail registers, slot fill count and the
// current task, and walks the linked queues through the link memory one
// access per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_core #(
  parameter int unsigned NUM_PRIORITIES = pts_pkg::NumPrioritiesDef,
  parameter int unsigned NUM_TASKS      = pts_pkg::NumTasksDef,
  localparam int unsigned TaskW = $clog2(NUM_TASKS)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire pts_pkg::cmd_t       cmd_i,
  input  wire logic                out_free_i,
  output logic                     idle_o,
  output pts_pkg::res_flags_t      res_o,
  output logic [TaskW-1:0]         handle_o,
  output logic [TaskW-1:0]         prev_o,
  output logic [TaskW-1:0]         next_o
);

  import pts_pkg::*;

  localparam int unsigned PrioW = $clog2(NUM_PRIORITIES);
  localparam int unsigned CntW  = $clog2(NUM_TASKS + 1);

  state_e state_q, state_d;

  logic [ActionW-1:0]        action_q;
  logic [PrioReqW-1:0]       prio_q;
  logic [NUM_PRIORITIES-1:0] ready_map_q, ready_map_d;
  logic [PrioW-1:0]          top_q, top_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [TaskW-1:0]          cur_task_q, cur_task_d;
  logic [PrioW-1:0]          cur_prio_q, cur_prio_d;
  logic                      running_q, running_d;
  logic [TaskW-1:0]          walk_q, walk_d;
  logic [CntW-1:0]           step_q, step_d;
  logic [StatusW-1:0]        status_q, status_d;
  logic                      sw_q, sw_d;
  logic [TaskW-1:0]          handle_q, handle_d;
  logic [TaskW-1:0]          prev_q, prev_d;
  logic [TaskW-1:0]          next_q, next_d;

  logic [TaskW-1:0] head_q [NUM_PRIORITIES];
  logic [TaskW-1:0] tail_q [NUM_PRIORITIES];

  // Queue register access, one index per cycle
  logic             is_start;
  logic             prio_ok;
  logic [PrioW-1:0] qidx;
  logic [TaskW-1:0] head_rd, tail_rd;
  logic             head_we, tail_we;
  logic [TaskW-1:0] head_wd, tail_wd;

  // Link memory port signals
  logic             mem_we, mem_re;
  logic [TaskW-1:0] mem_waddr, mem_wdata, mem_raddr, mem_rdata;
  logic [TaskW-1:0] slot;

  assign is_start = (action_q == ACT_START);
  assign prio_ok  = is_start || ({1'b0, prio_q} < (PrioReqW+1)'(NUM_PRIORITIES));
  // Ticks address the top priority, starts the idle priority 0, creates the requested one
  assign qidx     = (action_q == ACT_TICK) ? top_q :
                    (is_start ? '0 : prio_q[PrioW-1:0]);
  assign head_rd  = head_q[qidx];
  assign tail_rd  = tail_q[qidx];
  assign slot     = cnt_q[TaskW-1:0];

  pts_link_mem #(
    .Depth (NUM_TASKS),
    .Width (TaskW)
  ) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // State register and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ready_map_q <= '0;
      top_q       <= '0;
      cnt_q       <= '0;
      cur_task_q  <= '0;
      cur_prio_q  <= '0;
      running_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ready_map_q <= ready_map_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
      cur_task_q  <= cur_task_d;
      cur_prio_q  <= cur_prio_d;
      running_q   <= running_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.go && (state_q == S_IDLE)) begin
      action_q <= cmd_i.action;
      prio_q   <= cmd_i.prio;
    end
    walk_q   <= walk_d;
    step_q   <= step_d;
    status_q <= status_d;
    sw_q     <= sw_d;
    handle_q <= handle_d;
    prev_q   <= prev_d;
    next_q   <= next_d;
    if (head_we) begin
      head_q[qidx] <= head_wd;
    end
    if (tail_we) begin
      tail_q[qidx] <= tail_wd;
    end
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    ready_map_d = ready_map_q;
    top_d       = top_q;
    cnt_d       = cnt_q;
    cur_task_d  = cur_task_q;
    cur_prio_d  = cur_prio_q;
    running_d   = running_q;
    walk_d      = walk_q;
    step_d      = step_q;
    status_d    = status_q;
    sw_d        = sw_q;
    handle_d    = handle_q;
    prev_d      = prev_q;
    next_d      = next_q;
    head_we     = 1'b0;
    head_wd     = head_rd;
    tail_we     = 1'b0;
    tail_wd     = tail_rd;
    mem_we      = 1'b0;
    mem_waddr   = cur_task_q;
    mem_wdata   = cur_task_q;
    mem_re      = 1'b0;
    mem_raddr   = cur_task_q;
    res_o       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.go) begin
          status_d = ST_OK;
          sw_d     = 1'b0;
          handle_d = '0;
          prev_d   = '0;
          next_d   = '0;
          if ((cmd_i.action == ACT_CREATE) || (cmd_i.action == ACT_START)) begin
            state_d = S_CREATE;
          end else if (cmd_i.action == ACT_TICK) begin
            state_d = S_TICK;
          end else begin
            state_d = S_FIN;
          end
        end
      end

      // Slots are never freed, so the lowest free slot is the fill count
      S_CREATE: begin
        state_d = S_FIN;
        if (!prio_ok) begin
          status_d = ST_PRIO;
        end else if (cnt_q == CntW'(NUM_TASKS)) begin
          status_d = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = slot;
          mem_wdata = ready_map_q[qidx] ? head_rd : slot;
          if (!ready_map_q[qidx]) begin
            tail_we = 1'b1;
            tail_wd = slot;
          end
          head_we           = 1'b1;
          head_wd           = slot;
          ready_map_d[qidx] = 1'b1;
          if (qidx > top_q) begin
            top_d = qidx;
          end
          cnt_d    = cnt_q + CntW'(1);
          handle_d = slot;
          if (is_start) begin
            cur_task_d = slot;
            cur_prio_d = '0;
            running_d  = 1'b1;
          end
        end
      end

      // Top priority is tracked incrementally since bits are never cleared
      S_TICK: begin
        prev_d = cur_task_q;
        next_d = cur_task_q;
        if (ready_map_q == '0) begin
          status_d = ST_EMPTY;
          state_d  = S_FIN;
        end else if (!running_q) begin
          state_d = S_FIN;
        end else if (top_q == cur_prio_q) begin
          if (tail_rd == cur_task_q) begin
            state_d = S_PICK;
          end else if (head_rd == cur_task_q) begin
            mem_re    = 1'b1;
            mem_raddr = cur_task_q;
            state_d   = S_ROT_HEAD;
          end else begin
            walk_d    = head_rd;
            step_d    = '0;
            mem_re    = 1'b1;
            mem_raddr = head_rd;
            state_d   = S_ROT_WALK;
          end
        end else begin
          state_d = S_PICK;
        end
      end

      // Current task is the head: unlink it from the front
      S_ROT_HEAD: begin
        head_we = 1'b1;
        head_wd = mem_rdata;
        state_d = S_ROT_LINK;
      end

      // Walk the queue looking for the predecessor of the current task
      S_ROT_WALK: begin
        if (mem_rdata == cur_task_q) begin
          mem_re    = 1'b1;
          mem_raddr = cur_task_q;
          state_d   = S_ROT_SPLICE;
        end else if (walk_q == tail_rd) begin
          state_d = S_PICK;
        end else if (step_q == CntW'(NUM_TASKS - 1)) begin
          state_d = S_PICK;
        end else begin
          walk_d    = mem_rdata;
          step_d    = step_q + CntW'(1);
          mem_re    = 1'b1;
          mem_raddr = mem_rdata;
        end
      end

      // Predecessor skips over the current task
      S_ROT_SPLICE: begin
        mem_we    = 1'b1;
        mem_waddr = walk_q;
        mem_wdata = mem_rdata;
        state_d   = S_ROT_LINK;
      end

      // Old tail points at the current task
      S_ROT_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = tail_rd;
        mem_wdata = cur_task_q;
        state_d   = S_ROT_SELF;
      end

      // Current task becomes the self-linked tail
      S_ROT_SELF: begin
        mem_we    = 1'b1;
        mem_waddr = cur_task_q;
        mem_wdata = cur_task_q;
        tail_we   = 1'b1;
        tail_wd   = cur_task_q;
        state_d   = S_PICK;
      end

      S_PICK: begin
        next_d = head_rd;
        if (top_q >= cur_prio_q) begin
          sw_d       = 1'b1;
          cur_task_d = head_rd;
          cur_prio_d = top_q;
        end
        state_d = S_FIN;
      end

      // Hand the result over once the output register is free
      S_FIN: begin
        if (out_free_i) begin
          res_o.done = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.status = status_q;
    res_o.sw     = sw_q;
  end

  assign idle_o   = (state_q == S_IDLE);
  assign handle_o = handle_q;
  assign prev_o   = prev_q;
  assign next_o   = next_q;

endmodule : pts_core

`default_nettype wire

// File: hw/rtl/priority_task_scheduler.sv
// ----------------------------------------------------------------------------
// priority_task_scheduler: bitmap ready-queue scheduler with round robin
// Top level: handshakes, tick counter, configuration register and output
// register around the scheduler core.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready_o is high only while the sequencer
// is idle. A create or start beat passes the create state before its result
// is registered; an unused action goes straight to the finish state. A tick
// finishes directly when the ready map is empty or the scheduler is not
// started, and via the pick state when no rotation is needed. A current task
// that must move to the tail of its queue is unlinked from the front if it is
// the head, else the queue is walked one link per cycle through the
// registered read port to find and splice its predecessor. A finished item
// also waits while the output register still holds an untaken result. The
// output register lets the next beat be accepted while a result waits.
// A configuration beat loads the tick counter with the written value.
`default_nettype none

module priority_task_scheduler #(
  parameter int unsigned NUM_PRIORITIES = pts_pkg::NumPrioritiesDef,
  parameter int unsigned NUM_TASKS      = pts_pkg::NumTasksDef,
  localparam int unsigned TaskW = $clog2(NUM_TASKS)
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Configuration write
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [pts_pkg::TickW-1:0]    cfg_data_i,
  // Input items
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [pts_pkg::ActionW-1:0]  action_i,
  input  wire logic [pts_pkg::PrioReqW-1:0] priority_req_i,
  // Results
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [pts_pkg::StatusW-1:0]       status_o,
  output logic [TaskW-1:0]                  task_handle_o,
  output logic                              switch_needed_o,
  output logic [TaskW-1:0]                  prev_task_o,
  output logic [TaskW-1:0]                  next_task_o,
  output logic [pts_pkg::TickW-1:0]         tick_value_o
);

  import pts_pkg::*;

  cmd_t             cmd;
  res_flags_t       res;
  logic             core_idle;
  logic             in_fire;
  logic             out_free;
  logic [TaskW-1:0] core_handle, core_prev, core_next;

  logic [TickW-1:0] tick_count_q, tick_count_d;
  logic             out_valid_q, out_valid_d;

  logic [StatusW-1:0] status_q;
  logic [TaskW-1:0]   handle_q, prev_q, next_q;
  logic               sw_q;
  logic [TickW-1:0]   tick_val_q;

  assign in_ready_o  = core_idle;
  assign cfg_ready_o = 1'b1;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  assign cmd.go     = in_valid_i;
  assign cmd.action = action_i;
  assign cmd.prio   = priority_req_i;

  pts_core #(
    .NUM_PRIORITIES (NUM_PRIORITIES),
    .NUM_TASKS      (NUM_TASKS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .out_free_i (out_free),
    .idle_o     (core_idle),
    .res_o      (res),
    .handle_o   (core_handle),
    .prev_o     (core_prev),
    .next_o     (core_next)
  );

  // Tick counter: reload on a configuration beat, else count on a tick beat
  always_comb begin
    tick_count_d = tick_count_q;
    if (cfg_valid_i) begin
      tick_count_d = cfg_data_i;
    end else if (in_fire && (action_i == ACT_TICK)) begin
      tick_count_d = tick_count_q + TickW'(1);
    end
  end

  // Output valid: set on completion, cleared when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res.done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Start value after reset is zero, so the counter resets to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      tick_count_q <= tick_count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (res.done) begin
      status_q   <= res.status;
      sw_q       <= res.sw;
      handle_q   <= core_handle;
      prev_q     <= core_prev;
      next_q     <= core_next;
      tick_val_q <= tick_count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign task_handle_o   = handle_q;
  assign switch_needed_o = sw_q;
  assign prev_task_o     = prev_q;
  assign next_task_o     = next_q;
  assign tick_value_o    = tick_val_q;

endmodule : priority_task_scheduler

`default_nettype wire

// File: hw/rtl/pts_checker.sv
// ----------------------------------------------------------------------------
// pts_checker: port-level checks of the priority task scheduler
// Watches handshakes and result fields and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pts_checker #(
  parameter int unsigned NUM_TASKS = pts_pkg::NumTasksDef,
  localparam int unsigned TaskW = $clog2(NUM_TASKS)
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [pts_pkg::StatusW-1:0]  status_o,
  input wire logic [TaskW-1:0]             task_handle_o,
  input wire logic                         switch_needed_o,
  input wire logic [TaskW-1:0]             prev_task_o,
  input wire logic [TaskW-1:0]             next_task_o
);

  import pts_pkg::*;

  // A stalled result beat holds its status, handle and next task
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(status_o) && $stable(task_handle_o)
       && $stable(next_task_o)))
    else $error("result beat changed while stalled");

  // The sequencer is busy right after taking a beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again while busy");

  // A switch only comes with an ok status
  a_sw_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && switch_needed_o) |-> (status_o == ST_OK))
    else $error("switch with failing status");

  // Failures carry no handle
  a_fail_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (task_handle_o == '0))
    else $error("handle on a failed beat");

  // An empty ready map keeps the current task
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_EMPTY)) |->
      (!switch_needed_o && (prev_task_o == next_task_o)))
    else $error("empty tick changed task");

endmodule : pts_checker

bind priority_task_scheduler pts_checker #(
  .NUM_TASKS (NUM_TASKS)
) u_pts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .task_handle_o   (task_handle_o),
  .switch_needed_o (switch_needed_o),
  .prev_task_o     (prev_task_o),
  .next_task_o     (next_task_o)
);

`default_nettype wire
